>>> rtl/core/srs_pkg.sv
`default_nettype none

package srs_pkg;

   localparam int KEY_W   = 32;
   localparam int ROUTE_W = 32;
   localparam int IDX_W   = 8;
   localparam int SIZE_W  = 9;
   // search bounds carry one extra bit so that right can go below zero
   localparam int BOUND_W = SIZE_W + 1;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic STATUS_FOUND  = 1'b0;
   localparam logic STATUS_ABSENT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE
   } srs_state_type;

   typedef struct packed {
      logic               strobe;
      logic               status;
      logic [ROUTE_W-1:0] route;
   } srs_rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/sorted_table_route_search.sv
`default_nettype none

// Sorted key/route table with binary search. A request with req_op = write
// stores one key/route pair at req_entry_index in the cycle it is taken and
// gives no response; busy stays low, so requests may follow back to back.
// A search request walks positions 0 .. csr_entries_in_use-1 (capped at
// TABLE_DEPTH) and gives exactly one response, a single-cycle rsp_strobe
// that cannot be held off. Each probe reads the table memory in the probe
// state and compares the stored key in the compare state. A found key is
// answered from the compare state and an absent key from the probe state
// once the bounds cross; a search makes at most 9 probes for 256 entries,
// and an empty table answers without a probe. A new request is taken in
// the cycle the response is shown. The table is not cleared at reset:
// only written positions may be searched. csr_entries_in_use must be
// changed only while no search is running; the block does not enforce it.

module sorted_table_route_search #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic                          req_op,
   input  wire logic [srs_pkg::IDX_W-1:0]     req_entry_index,
   input  wire logic [srs_pkg::KEY_W-1:0]     req_lookup_key,
   input  wire logic [srs_pkg::ROUTE_W-1:0]   req_entry_route,
   output      logic                          rsp_strobe,
   output      logic                          rsp_search_status,
   output      logic [srs_pkg::ROUTE_W-1:0]   rsp_found_route,
   input  wire logic                          csr_write_enable,
   input  wire logic [srs_pkg::SIZE_W-1:0]    csr_entries_in_use
);

   import srs_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [SIZE_W-1:0]  entries_ff;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [KEY_W-1:0]   rd_key;
   logic [ROUTE_W-1:0] rd_route;
   srs_rsp_type        rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else if (csr_write_enable) begin
         entries_ff <= csr_entries_in_use;
      end
   end

   // writes beyond the table are dropped
   assign wr_en   = start && !busy && req_op == OP_WRITE
                    && 32'(req_entry_index) < TABLE_DEPTH;
   assign wr_addr = ADDR_W'(req_entry_index);

   srs_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (req_lookup_key),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_key)
   );

   srs_ram #(
      .WIDTH (ROUTE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_route_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (req_entry_route),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_route)
   );

   srs_search_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_search_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .op             (req_op),
      .lookup_key     (req_lookup_key),
      .entries_in_use (entries_ff),
      .busy           (busy),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_key         (rd_key),
      .rd_route       (rd_route),
      .rsp_ff         (rsp)
   );

   assign rsp_strobe        = rsp.strobe;
   assign rsp_search_status = rsp.status;
   assign rsp_found_route   = rsp.route;

endmodule

`default_nettype wire

>>> rtl/core/srs_ram.sv
`default_nettype none

module srs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/srs_search_ctrl.sv
`default_nettype none

module srs_search_ctrl #(
   parameter int TABLE_DEPTH = 256,
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         op,
   input  wire logic [srs_pkg::KEY_W-1:0]    lookup_key,
   input  wire logic [srs_pkg::SIZE_W-1:0]   entries_in_use,
   output      logic                         busy,
   output      logic                         rd_en,
   output      logic [ADDR_W-1:0]            rd_addr,
   input  wire logic [srs_pkg::KEY_W-1:0]    rd_key,
   input  wire logic [srs_pkg::ROUTE_W-1:0]  rd_route,
   output      srs_pkg::srs_rsp_type         rsp_ff
);

   import srs_pkg::*;

   srs_state_type        state_ff, state_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [BOUND_W-1:0]   left_ff, left_in;
   logic [BOUND_W-1:0]   right_ff, right_in;
   logic [SIZE_W-1:0]    mid_ff, mid_in;
   logic [SIZE_W-1:0]    mid;
   logic [SIZE_W-1:0]    size;
   srs_rsp_type          rsp_in;

   always_comb begin
      if (32'(entries_in_use) > TABLE_DEPTH) begin
         size = SIZE_W'(TABLE_DEPTH);
      end else begin
         size = entries_in_use;
      end
   end

   // only used while left <= right and both are non-negative
   assign mid = left_ff[SIZE_W-1:0] + SIZE_W'((right_ff - left_ff) >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_ff.strobe <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_ff.strobe <= rsp_in.strobe;
      end
      key_ff        <= key_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      mid_ff        <= mid_in;
      rsp_ff.status <= rsp_in.status;
      rsp_ff.route  <= rsp_in.route;
   end

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      mid_in        = mid_ff;
      rsp_in.strobe = 1'b0;
      rsp_in.status = STATUS_ABSENT;
      rsp_in.route  = '0;
      rd_en         = 1'b0;
      rd_addr       = ADDR_W'(mid);
      busy          = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (start && op == OP_SEARCH) begin
               key_in   = lookup_key;
               left_in  = '0;
               // an empty table wraps right to -1 and ends without a probe
               right_in = {1'b0, size} - BOUND_W'(1);
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (right_ff[BOUND_W-1] || left_ff > right_ff) begin
               rsp_in.strobe = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               mid_in   = mid;
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (rd_key == key_ff) begin
               rsp_in.strobe = 1'b1;
               rsp_in.status = STATUS_FOUND;
               rsp_in.route  = rd_route;
               state_in      = ST_IDLE;
            end else if (rd_key < key_ff) begin
               left_in  = {1'b0, mid_ff} + BOUND_W'(1);
               state_in = ST_PROBE;
            end else begin
               right_in = {1'b0, mid_ff} - BOUND_W'(1);
               state_in = ST_PROBE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/srs_checker.sv
`default_nettype none

module srs_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         req_op,
   input wire logic                         rsp_strobe,
   input wire logic                         rsp_search_status,
   input wire logic [srs_pkg::ROUTE_W-1:0]  rsp_found_route
);

   import srs_pkg::*;

   // a search that is taken raises busy in the cycle after
   a_search_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_SEARCH) |=> busy)
      else $error("search request did not raise busy");

   // a write request never produces a response
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_WRITE) |=> !rsp_strobe)
      else $error("response after a write request");

   // every response closes a search that held busy
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("response without a running search");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_search_status == STATUS_ABSENT) |-> rsp_found_route == '0)
      else $error("absent key with nonzero route");

endmodule

bind sorted_table_route_search srs_checker u_srs_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_op            (req_op),
   .rsp_strobe        (rsp_strobe),
   .rsp_search_status (rsp_search_status),
   .rsp_found_route   (rsp_found_route)
);

`default_nettype wire
